[hw/rtl/present80_block_encrypt_top_macros.svh]
// ----------------------------------------------------------------------------
// PRESENT-80 assertion macros
// Shared concurrent assertion forms for the cipher pipeline.
// ----------------------------------------------------------------------------
`ifndef PRESENT80_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define PRESENT80_BLOCK_ENCRYPT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PRES80_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRES80_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PRES80_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define PRES80_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

[hw/rtl/pres80_pkg.sv]
// ----------------------------------------------------------------------------
// pres80_pkg
// Types, constants and round functions of the PRESENT-80 cipher pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pres80_pkg;

  localparam int ROUND_COUNT = 31;
  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;
  localparam int KEY_LO_W    = 16;
  localparam int RND_W       = 5;
  localparam int CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

  // round number carried by the first cell
  localparam logic [RND_W-1:0] RND_FIRST = 5'd1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // one beat as it moves from cell to cell
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] state;
    logic [KEY_W-1:0]   key;
    logic [RND_W-1:0]   rnd;
  } stage_t;

  // substitution over all sixteen nibbles
  function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // bit j moves to 16*j mod 63 = {j[1:0], j[5:2]}; bit 63 lands on itself
  function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    logic [5:0]         j6;
    r = '0;
    for (int j = 0; j < BLOCK_W; j++) begin
      j6 = 6'(j);
      r[{j6[1:0], j6[5:2]}] = s[j];
    end
    return r;
  endfunction

  // one full round on the data path
  function automatic logic [BLOCK_W-1:0] round_state(input logic [BLOCK_W-1:0] s,
                                                     input logic [KEY_W-1:0]   k);
    return perm_layer(sub_layer(s ^ k[KEY_W-1:KEY_LO_W]));
  endfunction

  // key schedule: rotate left 61, S-box on top nibble, counter into bits 19..15
  function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] k,
                                                input logic [RND_W-1:0] rnd);
    logic [KEY_W-1:0] nk;
    nk          = {k[18:0], k[KEY_W-1:19]};
    nk[79:76]   = SBOX[nk[79:76]];
    nk[19:15]   = nk[19:15] ^ rnd;
    return nk;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/present80_block_encrypt_top.sv]
// ----------------------------------------------------------------------------
// present80_block_encrypt_top
// PRESENT-80 encryption as a chain of 31 round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write the 80-bit key first: cfg index 0 takes key bits 79..16, index 1
//   takes key bits 15..0 (low 16 bits of cfg_wdata). Writes take effect at
//   the clock edge where cfg_we is high; other indexes do not exist.
//   A plaintext beat is taken on each edge with start high and busy low.
//   busy is high only while in reset and for the first cycle after it, so a
//   new block may be started every cycle.
//   Each beat carries its own copy of the key through the chain, one round
//   cell per cycle, so the key seen at start is the one used.
//   The ciphertext shows on out_ciphertext for one cycle with out_valid
//   high, after the 31 round cells and then the output register.
//   Throughput is one block per cycle, set by the fully unrolled chain.
//   The receiver cannot stall; results come out in start order.
//   Synchronous reset clears the key registers to zero and drops all
//   beats in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "present80_block_encrypt_top_macros.svh"

module present80_block_encrypt_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // config port
  input  wire logic                                 cfg_we,
  input  wire logic [pres80_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pres80_pkg::BLOCK_W-1:0]       cfg_wdata,
  // input beat
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [pres80_pkg::BLOCK_W-1:0]       in_plaintext,
  // result beat
  output logic                                      out_valid,
  output logic [pres80_pkg::BLOCK_W-1:0]            out_ciphertext
);

  localparam int LAST = pres80_pkg::ROUND_COUNT;

  logic [pres80_pkg::KEY_W-1:0]   key_r;
  logic                           busy_r;
  logic                           out_valid_r;
  logic [pres80_pkg::BLOCK_W-1:0] ciphertext_r;
  logic                           accept;

  pres80_pkg::stage_t chain [LAST+1];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pres80_pkg::REG_KEY_UPPER: begin
          key_r[pres80_pkg::KEY_W-1:pres80_pkg::KEY_LO_W] <= cfg_wdata;
        end
        pres80_pkg::REG_KEY_LOWER: begin
          key_r[pres80_pkg::KEY_LO_W-1:0] <= cfg_wdata[pres80_pkg::KEY_LO_W-1:0];
        end
        default: begin
          key_r <= key_r;
        end
      endcase
    end
  end

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // head of the chain
  assign chain[0] = '{valid: accept, state: in_plaintext, key: key_r,
                      rnd: pres80_pkg::RND_FIRST};

  for (genvar g = 0; g < LAST; g++) begin : g_cell
    pres80_round_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .prev_stage (chain[g]),
      .next_stage (chain[g+1])
    );
  end

  // final whitening and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[LAST].valid;
    end
  end

  always_ff @(posedge clk) begin
    ciphertext_r <= chain[LAST].state ^
                    chain[LAST].key[pres80_pkg::KEY_W-1:pres80_pkg::KEY_LO_W];
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = ciphertext_r;

  `PRES80_ASSERT_NXT(a_accept_enters, clk, rst_n, accept, chain[1].valid,
                     "accepted beat missing from first cell")
  `PRES80_ASSERT_NXT(a_tail_strobe, clk, rst_n, chain[LAST].valid, out_valid_r,
                     "last cell beat not presented")
  `PRES80_ASSERT_NXT(a_no_spurious, clk, rst_n, !chain[LAST].valid, !out_valid_r,
                     "result strobe without a beat")
  `PRES80_ASSERT_IMP(a_tail_rnd, clk, rst_n, chain[LAST].valid,
                     chain[LAST].rnd == pres80_pkg::RND_W'(LAST + 1),
                     "beat reached the end with wrong round count")

endmodule

`default_nettype wire

[hw/rtl/pres80_round_cell.sv]
// ----------------------------------------------------------------------------
// pres80_round_cell
// One cipher round: registers the round output, next round key and counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "present80_block_encrypt_top_macros.svh"

module pres80_round_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pres80_pkg::stage_t prev_stage,
  output pres80_pkg::stage_t     next_stage
);

  logic                               valid_r;
  logic [pres80_pkg::BLOCK_W-1:0]     state_r;
  logic [pres80_pkg::KEY_W-1:0]       key_r;
  logic [pres80_pkg::RND_W-1:0]       rnd_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prev_stage.valid;
    end
  end

  // payload: round, key schedule, counter
  always_ff @(posedge clk) begin
    state_r <= pres80_pkg::round_state(prev_stage.state, prev_stage.key);
    key_r   <= pres80_pkg::key_next(prev_stage.key, prev_stage.rnd);
    rnd_r   <= prev_stage.rnd + pres80_pkg::RND_W'(1);
  end

  assign next_stage = '{valid: valid_r, state: state_r, key: key_r, rnd: rnd_r};

  `PRES80_ASSERT_NXT(a_valid_moves, clk, rst_n, prev_stage.valid, valid_r,
                     "cell dropped a beat")
  `PRES80_ASSERT_NXT(a_no_ghost, clk, rst_n, !prev_stage.valid, !valid_r,
                     "cell invented a beat")
  `PRES80_ASSERT_NXT(a_rnd_step, clk, rst_n, prev_stage.valid,
                     rnd_r == $past(prev_stage.rnd) + pres80_pkg::RND_W'(1),
                     "round counter did not advance")

endmodule

`default_nettype wire
